// ===== rtl/core/tssd_pkg.sv =====
`default_nettype none

package tssd_pkg;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_NULL = 2'd1,
    STATUS_CRC  = 2'd2
  } status_e;

  localparam logic [3:0]  LastPos        = 4'd8;
  localparam logic [3:0]  PosTempLow     = 4'd0;
  localparam logic [3:0]  PosTempHigh    = 4'd1;
  localparam logic [3:0]  PosConfig      = 4'd4;
  localparam logic [3:0]  PosCountRemain = 4'd6;
  localparam logic [3:0]  PosCountPerC   = 4'd7;
  localparam logic [7:0]  CrcPoly        = 8'h8C;
  localparam logic [7:0]  LegacyFullCnt  = 8'h10;
  localparam logic [15:0] LegacyMask     = 16'hFFF0;
  localparam logic [15:0] LegacyOffset   = 16'd12;

  // resolution bits of the config byte
  localparam logic [1:0]  Res9Bit        = 2'd0;
  localparam logic [1:0]  Res10Bit       = 2'd1;
  localparam logic [1:0]  Res11Bit       = 2'd2;
  localparam logic [1:0]  Res12Bit       = 2'd3;

  typedef struct packed {
    logic [7:0] temp_low;
    logic [7:0] temp_high;
    logic [1:0] res_code;
    logic [7:0] count_remain;
    logic       count_full;
  } scratch_t;

  // Dallas CRC-8, reflected, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] b;
    logic       mix;
    crc = crc_in;
    b   = data;
    for (int i = 0; i < 8; i++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tssd_temp_decode.sv =====
`default_nettype none

module tssd_temp_decode (
  input  var tssd_pkg::scratch_t fields_i,
  input  wire logic              legacy_i,
  output logic signed [15:0]     temperature_o
);
  import tssd_pkg::*;

  logic [15:0]        raw;
  logic [15:0]        shifted;
  logic signed [22:0] scaled;
  logic signed [22:0] biased;
  logic signed [18:0] quot;

  always_comb begin
    raw     = {fields_i.temp_high, fields_i.temp_low};
    shifted = raw;
    if (legacy_i) begin
      shifted = {raw[12:0], 3'b000};
      if (fields_i.count_full) begin
        shifted = (shifted & LegacyMask) + LegacyOffset - {8'd0, fields_i.count_remain};
      end
    end else begin
      case (fields_i.res_code)
        Res9Bit:  shifted = {raw[15:3], 3'b000};
        Res10Bit: shifted = {raw[15:2], 2'b00};
        Res11Bit: shifted = {raw[15:1], 1'b0};
        default:  shifted = raw;
      endcase
    end
  end

  // x100 then /16 truncating toward zero: bias negatives by 15 before the shift
  assign scaled = 23'(signed'(shifted)) * 23'sd100;
  assign biased = scaled + (scaled[22] ? 23'sd15 : 23'sd0);
  assign quot   = 19'(biased >>> 4);

  always_comb begin
    if (quot > 19'sd32767) begin
      temperature_o = 16'sh7FFF;
    end else if (quot < -19'sd32768) begin
      temperature_o = 16'sh8000;
    end else begin
      temperature_o = quot[15:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/temp_sensor_scratchpad_decode_top.sv =====
// Scratchpad decoder: one byte beat per cycle, no bubbles but for the byte 8 stall below.
// The result is registered in the output register in the cycle after byte 8 is taken.
// Throughput: 1 byte per cycle but for that stall; CRC step and temperature scaling are combinational logic.
// Input stalls only when byte 8 arrives while the previous result is still unread.
// Reset (async, active low) clears the frame position and output valid.
`default_nettype none

module temp_sensor_scratchpad_decode_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_start_i,
  input  wire logic        legacy_sensor_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic signed [15:0] temperature_o
);
  import tssd_pkg::*;

  logic [3:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_base, crc_next;
  logic        nz_q, nz_base, nz_next;
  scratch_t    fields_q;
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic signed [15:0] temp_q;

  logic        accept;
  logic        last_byte;
  logic        out_free;
  logic signed [15:0] temp_dec;
  status_e     status_d;

  assign pos       = (frame_start_i || pos_q > LastPos) ? PosTempLow : pos_q;
  assign last_byte = (pos == LastPos);
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = out_free || !last_byte;
  assign accept    = in_valid_i && in_ready_o;

  assign crc_base = (pos == PosTempLow) ? 8'd0 : crc_q;
  assign nz_base  = (pos == PosTempLow) ? 1'b0 : nz_q;
  assign crc_next = crc8_byte(crc_base, data_byte_i);
  assign nz_next  = nz_base || (data_byte_i != 8'd0);
  assign pos_d    = last_byte ? 4'd0 : pos + 4'd1;

  tssd_temp_decode u_decode (
    .fields_i      (fields_q),
    .legacy_i      (legacy_sensor_i),
    .temperature_o (temp_dec)
  );

  always_comb begin
    if (!nz_next) begin
      status_d = STATUS_NULL;
    end else if (crc_q != data_byte_i) begin
      status_d = STATUS_CRC;
    end else begin
      status_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q <= pos_d;
      end
      if (accept && last_byte) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // frame fields: every one is written before byte 8 can be reached
  always_ff @(posedge clk_i) begin
    if (accept && !last_byte) begin
      crc_q <= crc_next;
      nz_q  <= nz_next;
      case (pos)
        PosTempLow:     fields_q.temp_low     <= data_byte_i;
        PosTempHigh:    fields_q.temp_high    <= data_byte_i;
        PosConfig:      fields_q.res_code     <= data_byte_i[6:5];
        PosCountRemain: fields_q.count_remain <= data_byte_i;
        PosCountPerC:   fields_q.count_full   <= (data_byte_i == LegacyFullCnt);
        default: ;
      endcase
    end
    if (accept && last_byte) begin
      status_q <= status_d;
      temp_q   <= (status_d == STATUS_OK) ? temp_dec : 16'sd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign temperature_o = temp_q;

endmodule

`default_nettype wire
